[rtl/pnd_pkg.sv]
// Shared constants, codes and control types for the pilot notch and de-emphasis core.
package pnd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int GUARD_BITS      = 4;
  localparam int COEF_BITS       = 18;
  localparam int COEF_FRAC       = 16;
  localparam int ALPHA_BITS      = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = COEF_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_NOTCH_ENABLE = 3'd0,
    REG_ZERO_COEF    = 3'd1,
    REG_POLE_COEF1   = 3'd2,
    REG_POLE_COEF2   = 3'd3,
    REG_DEEMPH_ALPHA = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ZERO,
    MUL_POLE1,
    MUL_POLE2,
    MUL_ALPHA,
    MUL_WEIGHT
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_ADD,
    ACC_SUB,
    ACC_LOAD
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ZERO,
    ST_MUL_POLE1,
    ST_MUL_POLE2,
    ST_NOTCH_ACC,
    ST_NOTCH_RND,
    ST_MUL_ALPHA,
    ST_MUL_WEIGHT,
    ST_DEEMPH_ACC,
    ST_DEEMPH_RND
  } state_t;

  typedef struct packed {
    logic     in_load;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     notch_upd;
    logic     level_upd;
  } cmd_t;

  typedef struct packed {
    logic notch_en;
    logic out_busy;
  } status_t;

endpackage

[rtl/pnd_ctrl.sv]
// Sequencer that steps the shared multiplier and accumulator through one sample.
module pnd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pnd_pkg::status_t  status,
  output pnd_pkg::cmd_t     cmd
);

  pnd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.in_load   = 1'b0;
    cmd.mul_sel   = pnd_pkg::MUL_NONE;
    cmd.acc_op    = pnd_pkg::ACC_NONE;
    cmd.notch_upd = 1'b0;
    cmd.level_upd = 1'b0;
    unique case (state)
      pnd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = status.notch_en ? pnd_pkg::ST_MUL_ZERO : pnd_pkg::ST_MUL_ALPHA;
        end
      end
      pnd_pkg::ST_MUL_ZERO: begin
        cmd.mul_sel = pnd_pkg::MUL_ZERO;
        state_next  = pnd_pkg::ST_MUL_POLE1;
      end
      pnd_pkg::ST_MUL_POLE1: begin
        cmd.mul_sel = pnd_pkg::MUL_POLE1;
        cmd.acc_op  = pnd_pkg::ACC_ADD;
        state_next  = pnd_pkg::ST_MUL_POLE2;
      end
      pnd_pkg::ST_MUL_POLE2: begin
        cmd.mul_sel = pnd_pkg::MUL_POLE2;
        cmd.acc_op  = pnd_pkg::ACC_SUB;
        state_next  = pnd_pkg::ST_NOTCH_ACC;
      end
      pnd_pkg::ST_NOTCH_ACC: begin
        cmd.acc_op = pnd_pkg::ACC_SUB;
        state_next = pnd_pkg::ST_NOTCH_RND;
      end
      pnd_pkg::ST_NOTCH_RND: begin
        cmd.notch_upd = 1'b1;
        state_next    = pnd_pkg::ST_MUL_ALPHA;
      end
      pnd_pkg::ST_MUL_ALPHA: begin
        cmd.mul_sel = pnd_pkg::MUL_ALPHA;
        state_next  = pnd_pkg::ST_MUL_WEIGHT;
      end
      pnd_pkg::ST_MUL_WEIGHT: begin
        cmd.mul_sel = pnd_pkg::MUL_WEIGHT;
        cmd.acc_op  = pnd_pkg::ACC_LOAD;
        state_next  = pnd_pkg::ST_DEEMPH_ACC;
      end
      pnd_pkg::ST_DEEMPH_ACC: begin
        cmd.acc_op = pnd_pkg::ACC_ADD;
        state_next = pnd_pkg::ST_DEEMPH_RND;
      end
      pnd_pkg::ST_DEEMPH_RND: begin
        if (!status.out_busy) begin
          cmd.level_upd = 1'b1;
          state_next    = pnd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pnd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/pnd_datapath.sv]
// Registers, filter state, shared multiplier, accumulator and output register.
module pnd_datapath #(
  parameter int SAMPLE_BITS = pnd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [pnd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pnd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  pnd_pkg::cmd_t                          cmd,
  output pnd_pkg::status_t                       status,
  output logic [SAMPLE_BITS-1:0]                 audio,
  output logic                                   out_valid,
  input  logic                                   out_ready
);

  localparam int IB     = SAMPLE_BITS + pnd_pkg::GUARD_BITS;
  localparam int CB     = pnd_pkg::COEF_BITS;
  localparam int PROD_W = CB + IB;
  localparam int ACC_W  = IB + 20;
  localparam int RND_W  = ACC_W - pnd_pkg::COEF_FRAC;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (pnd_pkg::COEF_FRAC - 1);
  localparam logic signed [RND_W-1:0] INNER_MAX = RND_W'((64'sd1 <<< (IB - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] INNER_MIN = -INNER_MAX - RND_W'(1);
  localparam logic signed [IB-1:0] OUT_MAX = IB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [IB-1:0] OUT_MIN = -OUT_MAX - IB'(1);
  localparam logic signed [CB-1:0] ALPHA_ONE = CB'(1) <<< pnd_pkg::ALPHA_BITS;

  logic                                notch_enable;
  logic signed [CB-1:0]                zero_coef;
  logic signed [CB-1:0]                pole_coef1;
  logic signed [CB-1:0]                pole_coef2;
  logic [pnd_pkg::ALPHA_BITS-1:0]      alpha;

  logic signed [SAMPLE_BITS-1:0]       x_hold;
  logic signed [SAMPLE_BITS-1:0]       in_prev1;
  logic signed [SAMPLE_BITS-1:0]       in_prev2;
  logic signed [IB-1:0]                out_prev1;
  logic signed [IB-1:0]                out_prev2;
  logic signed [IB-1:0]                level;
  logic signed [IB-1:0]                v_hold;

  logic signed [CB-1:0]                mul_a;
  logic signed [IB-1:0]                mul_b;
  logic signed [PROD_W-1:0]            mul_res;
  logic signed [PROD_W-1:0]            prod;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             acc_half;
  logic signed [RND_W-1:0]             rnd;
  logic signed [IB-1:0]                sat;
  logic signed [SAMPLE_BITS-1:0]       sat_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      notch_enable <= 1'b0;
      zero_coef    <= '0;
      pole_coef1   <= '0;
      pole_coef2   <= '0;
      alpha        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pnd_pkg::REG_NOTCH_ENABLE: notch_enable <= cfg_data[0];
        pnd_pkg::REG_ZERO_COEF:    zero_coef    <= cfg_data;
        pnd_pkg::REG_POLE_COEF1:   pole_coef1   <= cfg_data;
        pnd_pkg::REG_POLE_COEF2:   pole_coef2   <= cfg_data;
        pnd_pkg::REG_DEEMPH_ALPHA: alpha        <= cfg_data[pnd_pkg::ALPHA_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      pnd_pkg::MUL_ZERO: begin
        mul_a = zero_coef;
        mul_b = IB'(in_prev1);
      end
      pnd_pkg::MUL_POLE1: begin
        mul_a = pole_coef1;
        mul_b = out_prev1;
      end
      pnd_pkg::MUL_POLE2: begin
        mul_a = pole_coef2;
        mul_b = out_prev2;
      end
      pnd_pkg::MUL_ALPHA: begin
        mul_a = CB'({1'b0, alpha});
        mul_b = level;
      end
      pnd_pkg::MUL_WEIGHT: begin
        mul_a = ALPHA_ONE - CB'({1'b0, alpha});
        mul_b = v_hold;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // round half up at 16 fraction bits, then clamp to the inner width and, for the output, to the sample width
  assign acc_half = acc + HALF;
  assign rnd      = acc_half[ACC_W-1:pnd_pkg::COEF_FRAC];

  always_comb begin
    if (rnd > INNER_MAX) begin
      sat = INNER_MAX[IB-1:0];
    end else if (rnd < INNER_MIN) begin
      sat = INNER_MIN[IB-1:0];
    end else begin
      sat = rnd[IB-1:0];
    end
    if (sat > OUT_MAX) begin
      sat_out = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (sat < OUT_MIN) begin
      sat_out = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_out = sat[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_res;
    if (cmd.in_load) begin
      x_hold <= sample_in;
      v_hold <= IB'(sample_in);
      acc    <= (ACC_W'(sample_in) + ACC_W'(in_prev2)) <<< pnd_pkg::COEF_FRAC;
    end else begin
      case (cmd.acc_op)
        pnd_pkg::ACC_ADD:  acc <= acc + ACC_W'(prod);
        pnd_pkg::ACC_SUB:  acc <= acc - ACC_W'(prod);
        pnd_pkg::ACC_LOAD: acc <= ACC_W'(prod);
        default: ;
      endcase
      if (cmd.notch_upd) begin
        v_hold <= sat;
      end
    end
    if (cmd.level_upd) begin
      audio <= sat_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_prev1  <= '0;
      in_prev2  <= '0;
      out_prev1 <= '0;
      out_prev2 <= '0;
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.notch_upd) begin
        in_prev2  <= in_prev1;
        in_prev1  <= x_hold;
        out_prev2 <= out_prev1;
        out_prev1 <= sat;
      end
      if (cmd.level_upd) begin
        level     <= sat;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.notch_en = notch_enable;
  assign status.out_busy = out_valid & ~out_ready;

endmodule

[rtl/pilot_notch_and_deemphasis_core.sv]
// Top level of the pilot notch and de-emphasis core: stream ports and config port.
// Each input word runs the notch stage (skipped with the notch off), then de-emphasis.
// A new word is taken once the last result is in the output register, which frees the input side
// but waits while m_tvalid is high and m_tready low. The pace comes from the single shared
// multiplier (18-bit coefficients), its product register and a round/saturate state per stage.
// rst (synchronous) clears the config and filter state to zero and empties the output.
module pilot_notch_and_deemphasis_core #(
  parameter int SAMPLE_BITS = pnd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pnd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pnd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // demod_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata    // audio_sample
);

  localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  pnd_pkg::cmd_t            cmd;
  pnd_pkg::status_t         status;
  logic [SAMPLE_BITS-1:0]   audio;

  pnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pnd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_in (s_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .audio     (audio),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = TDATA_W'(audio);

endmodule
